// ===== design/rrvg_pkg.sv =====
package rrvg_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_CORNER_POINTS_DEF = 256;
  localparam int ANGLE_BITS_DEF        = 16;

  // Fixed field and register widths
  localparam int IDX_W       = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int CFG_W       = 16;
  localparam int PTS_W       = 9;
  localparam int POINT_W     = 20;
  localparam int OUT_TDATA_W = 2 * POINT_W;
  localparam int CFG_ADDR_W  = 2;

  // Sine/cosine datapath
  localparam int TRIG_W       = 16;
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int TRIG_SHIFT   = 14;
  localparam int TRIG_PRE_W   = CORDIC_W - TRIG_SHIFT;
  localparam logic signed [CORDIC_W-1:0] CORDIC_START = 32'sd326006487;
  localparam logic signed [CORDIC_W-1:0] TRIG_RND     = 32'sd8192;
  localparam logic signed [TRIG_W-1:0]   TRIG_ONE     = 16'sd32767;

  // Configuration register map
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CORNER_RADIUS = 2'd2,
    REG_CORNER_POINTS = 2'd3
  } rrvg_reg_t;

  // Sideband that rides along with each item through the pipeline
  typedef struct packed {
    logic       valid;
    logic       err;
    logic [1:0] corner;
  } rrvg_tag_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic signed [CORDIC_W-1:0] atan_turn(input int step);
    logic signed [CORDIC_W-1:0] a;
    case (step)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10679838;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41722;
      15:      a = 32'sd20861;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clip a rounded CORDIC output to +/- one
  function automatic logic signed [TRIG_W-1:0] trig_sat(
    input logic signed [TRIG_PRE_W-1:0] v
  );
    logic signed [TRIG_W-1:0] r;
    if (v > TRIG_PRE_W'(TRIG_ONE)) begin
      r = TRIG_ONE;
    end else if (v < -TRIG_PRE_W'(TRIG_ONE)) begin
      r = -TRIG_ONE;
    end else begin
      r = v[TRIG_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/rrvg_divider.sv =====
// Restoring divider, one quotient bit per stage:
// quot = (pos * 2^(ANGLE_BITS-2) + half) / div, where pos <= div.
module rrvg_divider import rrvg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int POS_W      = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  rrvg_tag_t             tag_i,
  input  logic [POS_W-1:0]      pos_i,
  input  logic [POS_W-1:0]      div_i,
  input  logic [POS_W-1:0]      half_i,
  output rrvg_tag_t             tag_o,
  output logic [ANGLE_BITS-2:0] quot_o
);

  localparam int QB = ANGLE_BITS - 1;
  localparam int NW = POS_W + ANGLE_BITS - 2;

  rrvg_tag_t         tag_r [0:QB];
  logic [NW-1:0]     rem_r [0:QB];
  logic [QB-1:0]     quo_r [0:QB];

  // Numerator stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {pos_i, {(ANGLE_BITS-2){1'b0}}} + NW'(half_i);
      quo_r[0] <= '0;
    end
  end

  // One trial subtract per stage, MSB first
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [NW:0]   trial;
    logic [QB-1:0] quo_nxt;

    assign trial = {1'b0, rem_r[j]} - {1'b0, NW'(div_i) << K};

    always_comb begin
      quo_nxt    = quo_r[j];
      quo_nxt[K] = !trial[NW];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[j+1] <= '0;
      end else if (en) begin
        tag_r[j+1] <= tag_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= trial[NW] ? rem_r[j] : trial[NW-1:0];
        quo_r[j+1] <= quo_nxt;
      end
    end
  end

  assign tag_o  = tag_r[QB];
  assign quot_o = quo_r[QB];

endmodule

// ===== design/rrvg_cordic.sv =====
// Angle assembly, 16-stage rotation CORDIC, then rounding and quadrant fold.
module rrvg_cordic import rrvg_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  rrvg_tag_t                tag_i,
  input  logic [ANGLE_BITS-2:0]    quot_i,
  output rrvg_tag_t                tag_o,
  output logic signed [TRIG_W-1:0] cos_o,
  output logic signed [TRIG_W-1:0] sin_o
);

  rrvg_tag_t                  tag_r  [0:CORDIC_STEPS];
  logic [1:0]                 quad_r [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_r    [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_r    [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_r    [0:CORDIC_STEPS];

  // Angle: half turn + corner quarters + step, wrapping at one turn
  logic [ANGLE_BITS-1:0] angle;
  logic [CORDIC_W-1:0]   angle32;

  assign angle   = {2'(tag_i.corner + 2'd2), {(ANGLE_BITS-2){1'b0}}} + {1'b0, quot_i};
  assign angle32 = {angle, {(CORDIC_W-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r[0] <= '0;
    end else if (en) begin
      tag_r[0] <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r[0] <= angle32[CORDIC_W-1:CORDIC_W-2];
      x_r[0]    <= CORDIC_START;
      y_r[0]    <= '0;
      z_r[0]    <= $signed({2'b00, angle32[CORDIC_W-3:0]});
    end
  end

  // Rotation stages
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    logic                       ccw;

    assign dx  = y_r[i] >>> i;
    assign dy  = x_r[i] >>> i;
    assign ccw = !z_r[i][CORDIC_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tag_r[i+1] <= '0;
      end else if (en) begin
        tag_r[i+1] <= tag_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quad_r[i+1] <= quad_r[i];
        x_r[i+1]    <= ccw ? x_r[i] - dx : x_r[i] + dx;
        y_r[i+1]    <= ccw ? y_r[i] + dy : y_r[i] - dy;
        z_r[i+1]    <= ccw ? z_r[i] - atan_turn(i) : z_r[i] + atan_turn(i);
      end
    end
  end

  // Round to 16 bits, clip, fold back into the right quadrant
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [TRIG_W-1:0]   cr;
  logic signed [TRIG_W-1:0]   sr;
  logic signed [TRIG_W-1:0]   cos_nxt;
  logic signed [TRIG_W-1:0]   sin_nxt;
  rrvg_tag_t                  tag_t_r;
  logic signed [TRIG_W-1:0]   cos_r;
  logic signed [TRIG_W-1:0]   sin_r;

  assign xs = x_r[CORDIC_STEPS] + TRIG_RND;
  assign ys = y_r[CORDIC_STEPS] + TRIG_RND;
  assign cr = trig_sat(xs[CORDIC_W-1:TRIG_SHIFT]);
  assign sr = trig_sat(ys[CORDIC_W-1:TRIG_SHIFT]);

  always_comb begin
    case (quad_r[CORDIC_STEPS])
      2'd0: begin
        cos_nxt = cr;
        sin_nxt = sr;
      end
      2'd1: begin
        cos_nxt = -sr;
        sin_nxt = cr;
      end
      2'd2: begin
        cos_nxt = -cr;
        sin_nxt = -sr;
      end
      default: begin
        cos_nxt = sr;
        sin_nxt = -cr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_t_r <= '0;
    end else if (en) begin
      tag_t_r <= tag_r[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign tag_o = tag_t_r;
  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== design/rounded_rect_vertex_generator.sv =====
// Rounded rectangle outline generator: each input beat carries a vertex index and
// yields one output beat with the (x, y) point of that vertex, integer, no fraction bits,
// walking the four corner arcs clockwise from the top left. Indexes at or beyond
// four times the points per corner give the origin with out_tuser set. The block
// takes one beat per cycle while in_tready is high. A beat passes through the input
// register, the corner split, the one-bit-per-stage angle divider, the 16 CORDIC
// stages with their rounding register and the radius scaling. A two-entry output
// buffer lets the pipeline keep taking beats while one result waits; in_tready
// drops only when both entries are full.
// Configuration must be written only while no item is in flight.
module rounded_rect_vertex_generator import rrvg_pkg::*; #(
  parameter int MAX_CORNER_POINTS = MAX_CORNER_POINTS_DEF,
  parameter int ANGLE_BITS        = ANGLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] vertex_index
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [19:0] point_x, [39:20] point_y
  output logic [0:0]             out_tuser   // [0] index_error
);

  localparam int POS_W = (MAX_CORNER_POINTS > 512) ? PTS_W : $clog2(MAX_CORNER_POINTS);
  localparam int DW    = IDX_W + 2;
  localparam int PROD_W = CFG_W + 1 + TRIG_W;
  localparam int OFF_W  = PROD_W - 15;
  localparam logic signed [PROD_W-1:0] OFF_RND = PROD_W'(16384);

  // ---------------------------------------------------------------
  // Configuration registers, with derived values for the corner split
  // ---------------------------------------------------------------
  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic [CFG_W-1:0]   radius_r;
  logic [PTS_W-1:0]   pts_r;
  logic [PTS_W+1:0]   pts3_r;
  logic [POS_W-1:0]   divm1_r;
  logic [POS_W-1:0]   half_r;
  logic [PTS_W-1:0]   pts_nxt;
  logic [PTS_W-1:0]   ptsm1;

  // clamp points per corner to [2, MAX_CORNER_POINTS]
  always_comb begin
    pts_nxt = cfg_wdata[PTS_W-1:0];
    if (pts_nxt < PTS_W'(2)) begin
      pts_nxt = PTS_W'(2);
    end else if (32'(pts_nxt) > MAX_CORNER_POINTS) begin
      pts_nxt = PTS_W'(MAX_CORNER_POINTS);
    end
  end

  assign ptsm1 = pts_nxt - PTS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      radius_r <= '0;
      pts_r    <= PTS_W'(2);
      pts3_r   <= (PTS_W+2)'(6);
      divm1_r  <= POS_W'(1);
      half_r   <= '0;
    end else if (cfg_we) begin
      unique case (rrvg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:   width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT:  height_r <= cfg_wdata;
        REG_CORNER_RADIUS: radius_r <= cfg_wdata;
        REG_CORNER_POINTS: begin
          pts_r   <= pts_nxt;
          pts3_r  <= {2'b00, pts_nxt} + {1'b0, pts_nxt, 1'b0};
          divm1_r <= ptsm1[POS_W-1:0];
          half_r  <= POS_W'(ptsm1 >> 1);
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline advance: stalls only while the output buffer is full
  // ---------------------------------------------------------------
  logic [1:0] cnt_r;
  logic       adv;

  assign adv       = (cnt_r != 2'd2);
  assign in_tready = adv;

  // Input stage
  logic             in_v_r;
  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (adv) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r <= in_tdata[IDX_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // Corner split: compare against n, 2n, 3n, 4n in parallel
  // ---------------------------------------------------------------
  logic [DW-1:0]    d1, d2, d3, d4;
  rrvg_tag_t        sp_tag_nxt;
  logic [POS_W-1:0] sp_pos_nxt;
  rrvg_tag_t        sp_tag_r;
  logic [POS_W-1:0] sp_pos_r;

  assign d1 = {2'b00, idx_r} - {3'b000, pts_r};
  assign d2 = {2'b00, idx_r} - {2'b00, pts_r, 1'b0};
  assign d3 = {2'b00, idx_r} - {1'b0, pts3_r};
  assign d4 = {2'b00, idx_r} - {1'b0, pts_r, 2'b00};

  always_comb begin
    sp_tag_nxt.valid  = in_v_r;
    sp_tag_nxt.err    = 1'b0;
    sp_tag_nxt.corner = 2'd0;
    sp_pos_nxt        = idx_r[POS_W-1:0];
    if (!d4[DW-1]) begin
      sp_tag_nxt.err = 1'b1;
      sp_pos_nxt     = '0;
    end else if (!d3[DW-1]) begin
      sp_tag_nxt.corner = 2'd3;
      sp_pos_nxt        = d3[POS_W-1:0];
    end else if (!d2[DW-1]) begin
      sp_tag_nxt.corner = 2'd2;
      sp_pos_nxt        = d2[POS_W-1:0];
    end else if (!d1[DW-1]) begin
      sp_tag_nxt.corner = 2'd1;
      sp_pos_nxt        = d1[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_tag_r <= '0;
    end else if (adv) begin
      sp_tag_r <= sp_tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_pos_r <= sp_pos_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Angle step within the corner, then sine and cosine
  // ---------------------------------------------------------------
  rrvg_tag_t                dv_tag;
  logic [ANGLE_BITS-2:0]    dv_quot;
  rrvg_tag_t                cd_tag;
  logic signed [TRIG_W-1:0] cd_cos;
  logic signed [TRIG_W-1:0] cd_sin;

  rrvg_divider #(
    .ANGLE_BITS (ANGLE_BITS),
    .POS_W      (POS_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .tag_i  (sp_tag_r),
    .pos_i  (sp_pos_r),
    .div_i  (divm1_r),
    .half_i (half_r),
    .tag_o  (dv_tag),
    .quot_o (dv_quot)
  );

  rrvg_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .tag_i  (dv_tag),
    .quot_i (dv_quot),
    .tag_o  (cd_tag),
    .cos_o  (cd_cos),
    .sin_o  (cd_sin)
  );

  // ---------------------------------------------------------------
  // Radius scaling
  // ---------------------------------------------------------------
  rrvg_tag_t                m_tag_r;
  logic signed [PROD_W-1:0] prodx_r;
  logic signed [PROD_W-1:0] prody_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_tag_r <= '0;
    end else if (adv) begin
      m_tag_r <= cd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prodx_r <= $signed({1'b0, radius_r}) * cd_cos;
      prody_r <= $signed({1'b0, radius_r}) * cd_sin;
    end
  end

  // ---------------------------------------------------------------
  // Center plus rounded offset
  // ---------------------------------------------------------------
  logic signed [PROD_W-1:0] sumx, sumy;
  logic signed [OFF_W-1:0]  offx, offy;
  logic signed [CFG_W:0]    cx, cy;
  logic signed [CFG_W:0]    rad_s;
  logic [POINT_W-1:0]       fx_nxt, fy_nxt;

  assign sumx  = prodx_r + OFF_RND;
  assign sumy  = prody_r + OFF_RND;
  assign offx  = sumx[PROD_W-1:15];
  assign offy  = sumy[PROD_W-1:15];
  assign rad_s = $signed({1'b0, radius_r});

  always_comb begin
    cx = (m_tag_r.corner == 2'd1 || m_tag_r.corner == 2'd2) ?
         $signed({1'b0, width_r}) - rad_s : rad_s;
    cy = (m_tag_r.corner[1]) ? $signed({1'b0, height_r}) - rad_s : rad_s;
    if (m_tag_r.err) begin
      fx_nxt = '0;
      fy_nxt = '0;
    end else begin
      fx_nxt = {{(POINT_W-CFG_W-1){cx[CFG_W]}}, cx} +
               {{(POINT_W-OFF_W){offx[OFF_W-1]}}, offx};
      fy_nxt = {{(POINT_W-CFG_W-1){cy[CFG_W]}}, cy} +
               {{(POINT_W-OFF_W){offy[OFF_W-1]}}, offy};
    end
  end

  // ---------------------------------------------------------------
  // Two-entry output buffer
  // ---------------------------------------------------------------
  logic [POINT_W-1:0] fx_r [0:1];
  logic [POINT_W-1:0] fy_r [0:1];
  logic               fe_r [0:1];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic               push;
  logic               pop;

  assign push = adv && m_tag_r.valid;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fx_r[wr_ptr_r] <= fx_nxt;
      fy_r[wr_ptr_r] <= fy_nxt;
      fe_r[wr_ptr_r] <= m_tag_r.err;
    end
  end

  assign out_tvalid   = (cnt_r != 2'd0);
  assign out_tdata    = {fy_r[rd_ptr_r], fx_r[rd_ptr_r]};
  assign out_tuser[0] = fe_r[rd_ptr_r];

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_err_origin : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error beat carries a nonzero point");

  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  a_pts_range : assert property (@(posedge clk) disable iff (!rst_n)
    pts_r >= PTS_W'(2) && 32'(pts_r) <= MAX_CORNER_POINTS)
    else $error("points per corner out of range");

  a_pts3 : assert property (@(posedge clk) disable iff (!rst_n)
    pts3_r == {2'b00, pts_r} + {1'b0, pts_r, 1'b0})
    else $error("three-corner bound out of step with points per corner");

endmodule
